>>> design/cllm_pkg.sv
// Shared types, codes and the microcode table for the cursor linked list manager.
// Used by cursor_linked_list_manager; depends on nothing else.
package cllm_pkg;

   localparam int CELLS_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 16;
   localparam int POS_W              = 6;
   localparam int MODE_W             = 3;
   localparam int STATUS_W           = 2;

   typedef enum logic [MODE_W-1:0] {
      M_INSERT, M_DELETE, M_READ, M_WRITE, M_NEXT, M_PREV, M_LAST, M_CLEAR
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   // Microprogram addresses
   typedef enum logic [5:0] {
      S_IDLE, S_CHECK, S_ERR, S_FULL, S_DONE,
      S_INS0, S_INS_H0, S_INS_H1, S_INS_WS, S_INS_WL, S_INS_F0, S_INS_F1, S_INS_F2,
      S_DEL0, S_DEL_H0, S_DEL_H1, S_DEL_WS, S_DEL_WL, S_DEL_F0, S_DEL_F1, S_DEL_F2,
      S_RD0, S_RD1, S_WR0, S_WR1, S_NXT0, S_NXT1,
      S_PRV0, S_PRV_HEAD, S_PRV_WS, S_PRV_WL, S_PRV_HIT,
      S_LST0, S_CLR0
   } step_type;

   // Jump conditions
   typedef enum logic [3:0] {
      C_NEVER, C_REQ, C_BADPOS, C_FULL, C_POS_HEAD, C_POS_NULL,
      C_HEAD_NULL, C_HIT, C_WALK_END, C_OUT_FREE
   } cond_type;

   // Datapath transfers, one per step
   typedef enum logic [4:0] {
      A_NONE, A_LATCH, A_SET_ERR, A_SET_FULL, A_EMIT,
      A_RD_FREE, A_ALLOC_HEAD, A_WALK_START, A_WALK_STEP, A_ALLOC, A_LINK_PIVOT,
      A_RD_POS, A_DEL_HEAD, A_UNLINK, A_FREE_POS,
      A_RD_ELEM, A_TAKE_ELEM, A_WR_ELEM, A_TAKE_NEXT,
      A_RPOS_HEAD, A_RPOS_CUR, A_CLEAR
   } act_type;

   typedef struct packed {
      act_type  act;
      cond_type c1;
      step_type t1;
      cond_type c2;
      step_type t2;
      step_type nxt;
      logic     dsp;
   } ucode_type;

   function automatic ucode_type uw(act_type a, cond_type c1, step_type t1,
                                    cond_type c2, step_type t2, step_type nxt,
                                    logic dsp);
      ucode_type w;
      w.act = a;
      w.c1  = c1;
      w.t1  = t1;
      w.c2  = c2;
      w.t2  = t2;
      w.nxt = nxt;
      w.dsp = dsp;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      w = uw(A_NONE, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_IDLE, 1'b0);
      unique case (s)
         S_IDLE:     w = uw(A_LATCH, C_REQ, S_CHECK, C_NEVER, S_IDLE, S_IDLE, 1'b0);
         S_CHECK:    w = uw(A_NONE, C_BADPOS, S_ERR, C_NEVER, S_IDLE, S_IDLE, 1'b1);
         S_ERR:      w = uw(A_SET_ERR, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         S_FULL:     w = uw(A_SET_FULL, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         S_DONE:     w = uw(A_EMIT, C_OUT_FREE, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         // insert: fullness first, then before-head, else walk for the predecessor
         S_INS0:     w = uw(A_NONE, C_FULL, S_FULL, C_POS_HEAD, S_INS_H0, S_INS_WS, 1'b0);
         S_INS_H0:   w = uw(A_RD_FREE, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_INS_H1, 1'b0);
         S_INS_H1:   w = uw(A_ALLOC_HEAD, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         S_INS_WS:   w = uw(A_WALK_START, C_HEAD_NULL, S_ERR, C_NEVER, S_IDLE,
                            S_INS_WL, 1'b0);
         S_INS_WL:   w = uw(A_WALK_STEP, C_HIT, S_INS_F0, C_WALK_END, S_ERR,
                            S_INS_WL, 1'b0);
         S_INS_F0:   w = uw(A_RD_FREE, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_INS_F1, 1'b0);
         S_INS_F1:   w = uw(A_ALLOC, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_INS_F2, 1'b0);
         S_INS_F2:   w = uw(A_LINK_PIVOT, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         // delete
         S_DEL0:     w = uw(A_NONE, C_POS_NULL, S_ERR, C_POS_HEAD, S_DEL_H0, S_DEL_WS, 1'b0);
         S_DEL_H0:   w = uw(A_RD_POS, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DEL_H1, 1'b0);
         S_DEL_H1:   w = uw(A_DEL_HEAD, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         S_DEL_WS:   w = uw(A_WALK_START, C_HEAD_NULL, S_ERR, C_NEVER, S_IDLE,
                            S_DEL_WL, 1'b0);
         S_DEL_WL:   w = uw(A_WALK_STEP, C_HIT, S_DEL_F0, C_WALK_END, S_ERR,
                            S_DEL_WL, 1'b0);
         S_DEL_F0:   w = uw(A_RD_POS, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DEL_F1, 1'b0);
         S_DEL_F1:   w = uw(A_UNLINK, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DEL_F2, 1'b0);
         S_DEL_F2:   w = uw(A_FREE_POS, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         // direct cell access
         S_RD0:      w = uw(A_RD_ELEM, C_POS_NULL, S_ERR, C_NEVER, S_IDLE, S_RD1, 1'b0);
         S_RD1:      w = uw(A_TAKE_ELEM, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         S_WR0:      w = uw(A_NONE, C_POS_NULL, S_ERR, C_NEVER, S_IDLE, S_WR1, 1'b0);
         S_WR1:      w = uw(A_WR_ELEM, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         S_NXT0:     w = uw(A_RD_POS, C_POS_NULL, S_ERR, C_NEVER, S_IDLE, S_NXT1, 1'b0);
         S_NXT1:     w = uw(A_TAKE_NEXT, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         // previous and last share one walk
         S_PRV0:     w = uw(A_NONE, C_POS_HEAD, S_PRV_HEAD, C_NEVER, S_IDLE, S_PRV_WS, 1'b0);
         S_PRV_HEAD: w = uw(A_RPOS_HEAD, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         S_PRV_WS:   w = uw(A_WALK_START, C_HEAD_NULL, S_ERR, C_NEVER, S_IDLE,
                            S_PRV_WL, 1'b0);
         S_PRV_WL:   w = uw(A_WALK_STEP, C_HIT, S_PRV_HIT, C_WALK_END, S_ERR,
                            S_PRV_WL, 1'b0);
         S_PRV_HIT:  w = uw(A_RPOS_CUR, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         S_LST0:     w = uw(A_NONE, C_HEAD_NULL, S_DONE, C_NEVER, S_IDLE, S_PRV_WS, 1'b0);
         S_CLR0:     w = uw(A_CLEAR, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_DONE, 1'b0);
         default:    w = uw(A_NONE, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_IDLE, 1'b0);
      endcase
      return w;
   endfunction

   function automatic step_type mode_entry(mode_type m);
      step_type s;
      s = S_IDLE;
      unique case (m)
         M_INSERT: s = S_INS0;
         M_DELETE: s = S_DEL0;
         M_READ:   s = S_RD0;
         M_WRITE:  s = S_WR0;
         M_NEXT:   s = S_NXT0;
         M_PREV:   s = S_PRV0;
         M_LAST:   s = S_LST0;
         M_CLEAR:  s = S_CLR0;
      endcase
      return s;
   endfunction

endpackage

>>> design/cursor_linked_list_manager.sv
// Cursor linked list manager: microcoded sequencer, link store and element store.
// Depends on cllm_pkg for codes, types and the microcode table.
//
// Usage: one request beat on req_* (mode, position, data) yields exactly one
// response beat on rsp_* (result_position, result_data, list_empty, status).
// A beat moves at a rising edge with valid high and stall low. req_stall is
// high while a request is being worked on; a new request is taken as soon as
// the previous one has been placed in the response register, even if the
// receiver still holds rsp_stall, so a stalled response lets the next one in.
// Read, write, next and clear run straight through their steps; insert,
// delete, previous and last walk the link store one link per cycle through
// its single read port. One request is in flight at a time.
// Reset is synchronous and immediate: the list is empty and all cells are
// free; cells at or above a fill mark read as linking to the next cell, so no
// clearing pass over the link store is needed. Clear list also takes one step.
// While rsp_stall is high the response holds and the sequencer waits at its
// final step until the response register frees.
module cursor_linked_list_manager
   import cllm_pkg::*;
#(
   parameter int CELLS      = CELLS_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [POS_W-1:0]      req_position,
   input  logic [DATA_WIDTH-1:0] req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_W-1:0]      rsp_result_position,
   output logic [DATA_WIDTH-1:0] rsp_result_data,
   output logic                  rsp_list_empty,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int IW = $clog2(CELLS);
   localparam int LW = $clog2(CELLS + 1);

   // sequencer and datapath registers
   step_type              upc_ff, upc_in;
   mode_type              mode_ff, mode_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [IW-1:0]         head_ff, head_in;
   logic [LW-1:0]         free_ff, free_in;
   logic [LW-1:0]         hw_ff, hw_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic [IW-1:0]         cell_ff, cell_in;
   logic [POS_W-1:0]      rpos_ff, rpos_in;
   logic [DATA_WIDTH-1:0] rdata_ff, rdata_in;
   status_type            status_ff, status_in;
   logic [IW-1:0]         raddr_ff, raddr_in;
   logic                  impl_ff, impl_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   status_type            rsp_status_ff, rsp_status_in;

   // stores
   logic [LW-1:0]         link_mem [CELLS];
   logic [LW-1:0]         link_q_ff;
   logic [DATA_WIDTH-1:0] elem_mem [CELLS];
   logic [DATA_WIDTH-1:0] elem_q_ff;

   logic                  link_re, link_we, elem_re, elem_we;
   logic [IW-1:0]         link_ra, link_wa, elem_wa;
   logic [LW-1:0]         link_wd;

   ucode_type             uc;
   logic [15:0]           cond_vec;
   logic [LW-1:0]         link_val;
   logic [LW-1:0]         target;
   logic                  hit;
   logic                  out_free;

   assign uc       = ucode_rom(upc_ff);
   // cells at or above the fill mark were never written and still link onward
   assign link_val = impl_ff ? (LW'(raddr_ff) + LW'(1)) : link_q_ff;
   assign target   = (mode_ff == M_LAST) ? '0 : LW'(pos_ff);
   assign hit      = (link_val == target);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cond_vec              = '0;
      cond_vec[C_REQ]       = req_valid;
      cond_vec[C_BADPOS]    = (mode_ff != M_LAST) && (mode_ff != M_CLEAR)
                              && (32'(pos_ff) >= CELLS);
      cond_vec[C_FULL]      = (free_ff == '0) || (32'(free_ff) >= CELLS);
      cond_vec[C_POS_HEAD]  = (32'(pos_ff) == 32'(head_ff));
      cond_vec[C_POS_NULL]  = (pos_ff == '0);
      cond_vec[C_HEAD_NULL] = (head_ff == '0);
      cond_vec[C_HIT]       = hit;
      cond_vec[C_WALK_END]  = (32'(cnt_ff) + 1 == CELLS) || (link_val == '0)
                              || (32'(link_val) >= CELLS);
      cond_vec[C_OUT_FREE]  = out_free;
   end

   always_comb begin
      priority if (cond_vec[uc.c1]) begin
         upc_in = uc.t1;
      end else if (cond_vec[uc.c2]) begin
         upc_in = uc.t2;
      end else if (uc.dsp) begin
         upc_in = mode_entry(mode_ff);
      end else begin
         upc_in = uc.nxt;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      data_in       = data_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      hw_in         = hw_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      cell_in       = cell_ff;
      rpos_in       = rpos_ff;
      rdata_in      = rdata_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pos_in    = rsp_pos_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      link_re       = 1'b0;
      link_ra       = IW'(pos_ff);
      link_we       = 1'b0;
      link_wa       = IW'(pos_ff);
      link_wd       = free_ff;
      elem_re       = 1'b0;
      elem_we       = 1'b0;
      elem_wa       = IW'(pos_ff);

      unique case (uc.act)
         A_NONE: begin
         end
         A_LATCH: begin
            if (req_valid) begin
               mode_in   = mode_type'(req_mode);
               pos_in    = req_position;
               data_in   = req_data;
               rpos_in   = '0;
               rdata_in  = '0;
               status_in = ST_OK;
            end
         end
         A_SET_ERR:  status_in = ST_MISSING;
         A_SET_FULL: status_in = ST_FULL;
         A_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = rpos_ff;
               rsp_data_in   = rdata_ff;
               rsp_empty_in  = (head_ff == '0);
               rsp_status_in = status_ff;
            end
         end
         A_RD_FREE: begin
            link_re = 1'b1;
            link_ra = IW'(free_ff);
         end
         A_ALLOC_HEAD: begin
            link_we = 1'b1;
            link_wa = IW'(free_ff);
            link_wd = LW'(pos_ff);
            elem_we = 1'b1;
            elem_wa = IW'(free_ff);
            free_in = link_val;
            head_in = IW'(free_ff);
            rpos_in = POS_W'(free_ff);
         end
         A_WALK_START: begin
            cur_in  = head_ff;
            cnt_in  = '0;
            link_re = 1'b1;
            link_ra = head_ff;
         end
         A_WALK_STEP: begin
            // hold the cursor on a hit: it is the predecessor
            if (!hit) begin
               cur_in  = IW'(link_val);
               cnt_in  = cnt_ff + IW'(1);
               link_re = 1'b1;
               link_ra = IW'(link_val);
            end
         end
         A_ALLOC: begin
            link_we = 1'b1;
            link_wa = IW'(free_ff);
            link_wd = LW'(pos_ff);
            elem_we = 1'b1;
            elem_wa = IW'(free_ff);
            free_in = link_val;
            cell_in = IW'(free_ff);
            rpos_in = POS_W'(free_ff);
         end
         A_LINK_PIVOT: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = LW'(cell_ff);
         end
         A_RD_POS: begin
            link_re = 1'b1;
            link_ra = IW'(pos_ff);
         end
         A_DEL_HEAD: begin
            head_in = IW'(link_val);
            link_we = 1'b1;
            link_wa = IW'(pos_ff);
            link_wd = free_ff;
            free_in = LW'(pos_ff);
            rpos_in = POS_W'(link_val);
         end
         A_UNLINK: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = link_val;
         end
         A_FREE_POS: begin
            link_we = 1'b1;
            link_wa = IW'(pos_ff);
            link_wd = free_ff;
            free_in = LW'(pos_ff);
            rpos_in = POS_W'(head_ff);
         end
         A_RD_ELEM: elem_re = 1'b1;
         A_TAKE_ELEM: begin
            rdata_in = elem_q_ff;
            rpos_in  = pos_ff;
         end
         A_WR_ELEM: begin
            elem_we = 1'b1;
            rpos_in = pos_ff;
         end
         A_TAKE_NEXT: rpos_in = (32'(link_val) < CELLS) ? POS_W'(link_val) : '0;
         A_RPOS_HEAD: rpos_in = POS_W'(head_ff);
         A_RPOS_CUR:  rpos_in = POS_W'(cur_ff);
         A_CLEAR: begin
            head_in = '0;
            free_in = LW'(1);
            hw_in   = LW'(1);
         end
         default: begin
         end
      endcase

      // advance the fill mark when the first unwritten cell is taken
      if (link_we && (LW'(link_wa) == hw_ff)) begin
         hw_in = hw_ff + LW'(1);
      end

      raddr_in = link_re ? link_ra : raddr_ff;
      impl_in  = link_re ? (LW'(link_ra) >= hw_ff) : impl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= S_IDLE;
         head_ff      <= '0;
         free_ff      <= LW'(1);
         hw_ff        <= LW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      data_ff       <= data_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      cell_ff       <= cell_in;
      rpos_ff       <= rpos_in;
      rdata_ff      <= rdata_in;
      status_ff     <= status_in;
      raddr_ff      <= raddr_in;
      impl_ff       <= impl_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_q_ff <= link_mem[link_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_wa] <= data_ff;
      end
      if (elem_re) begin
         elem_q_ff <= elem_mem[IW'(pos_ff)];
      end
   end

   assign req_stall           = (upc_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_position = rsp_pos_ff;
   assign rsp_result_data     = rsp_data_ff;
   assign rsp_list_empty      = rsp_empty_ff;
   assign rsp_status          = rsp_status_ff;

endmodule
